// ===== design/psds_pkg.sv =====
package psds_pkg;

  // Default plane limit and the fixed field widths of the block.
  localparam int MaxPlanesDef = 256;
  localparam int ChanW        = 8;
  localparam int CostW        = 10;
  localparam int PlaneW       = 8;
  localparam int DepthW       = 8;
  localparam int NumPlanesW   = 9;
  localparam int DepthStepW   = 8;
  localparam int CfgAddrW     = 3;
  localparam int CfgDataW     = 32;

  // Cost limits and depth saturation.
  localparam logic [CostW-1:0]  CostMax   = 10'd765;
  localparam logic [CostW-1:0]  CostReset = 10'h3FF;
  localparam logic [DepthW-1:0] DepthSat  = 8'd255;

  // Register reset values.
  localparam logic [NumPlanesW-1:0] NumPlanesRst = 9'd200;
  localparam logic [DepthStepW-1:0] DepthStepRst = 8'd1;

  // Register indexes, taken from the word address.
  typedef enum logic {
    RegNumPlanes = 1'b0,
    RegDepthStep = 1'b1
  } reg_idx_e;

  // Configuration handed from the register block to the selection logic.
  typedef struct packed {
    logic [NumPlanesW-1:0] num_planes;
    logic [DepthStepW-1:0] depth_step;
  } cfg_t;

  // Difference a - b, held at zero where b is larger.
  function automatic logic [ChanW-1:0] sat_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

// ===== design/psds_cfg.sv =====
module psds_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psds_pkg::CfgAddrW-1:0] paddr,
  input  logic [psds_pkg::CfgDataW-1:0] pwdata,
  output logic [psds_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output psds_pkg::cfg_t                cfg_o
);
  import psds_pkg::*;

  logic [NumPlanesW-1:0] num_planes_q;
  logic [DepthStepW-1:0] depth_step_q;
  logic                  wr_en;
  reg_idx_e              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  // Register writes on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_planes_q <= NumPlanesRst;
      depth_step_q <= DepthStepRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegNumPlanes: num_planes_q <= pwdata[NumPlanesW-1:0];
        RegDepthStep: depth_step_q <= pwdata[DepthStepW-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_idx)
      RegNumPlanes: prdata = CfgDataW'(num_planes_q);
      RegDepthStep: prdata = CfgDataW'(depth_step_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.num_planes = num_planes_q;
  assign cfg_o.depth_step = depth_step_q;

endmodule

// ===== design/psds_cost.sv =====
module psds_cost (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [psds_pkg::ChanW-1:0] ref_blue_i,
  input  logic [psds_pkg::ChanW-1:0] ref_green_i,
  input  logic [psds_pkg::ChanW-1:0] ref_red_i,
  input  logic [psds_pkg::ChanW-1:0] warp_blue_i,
  input  logic [psds_pkg::ChanW-1:0] warp_green_i,
  input  logic [psds_pkg::ChanW-1:0] warp_red_i,
  output logic                       valid_o,
  input  logic                       take_i,
  output logic [psds_pkg::CostW-1:0] cost_o
);
  import psds_pkg::*;

  logic             valid_q;
  logic [ChanW-1:0] ref_b_q, ref_g_q, ref_r_q;
  logic [ChanW-1:0] warp_b_q, warp_g_q, warp_r_q;
  logic             load;

  // The stage takes a new word whenever it is empty or its word moves on.
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ref_b_q  <= ref_blue_i;
      ref_g_q  <= ref_green_i;
      ref_r_q  <= ref_red_i;
      warp_b_q <= warp_blue_i;
      warp_g_q <= warp_green_i;
      warp_r_q <= warp_red_i;
    end
  end

  // Matching cost: sum of the three clamped channel differences.
  assign cost_o  = CostW'(sat_diff(ref_b_q, warp_b_q)) +
                   CostW'(sat_diff(ref_g_q, warp_g_q)) +
                   CostW'(sat_diff(ref_r_q, warp_r_q));
  assign valid_o = valid_q;

endmodule

// ===== design/psds_wta.sv =====
module psds_wta #(
  parameter int MAX_PLANES = psds_pkg::MaxPlanesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psds_pkg::cfg_t              cfg_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [psds_pkg::CostW-1:0]  cost_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [psds_pkg::DepthW-1:0] depth_value_o,
  output logic [psds_pkg::PlaneW-1:0] best_plane_o,
  output logic [psds_pkg::CostW-1:0]  best_cost_o
);
  import psds_pkg::*;

  localparam int CntW  = $clog2(MAX_PLANES);
  localparam int ProdW = DepthStepW + CntW + 1;
  localparam logic [NumPlanesW-1:0] MaxPlanesN = NumPlanesW'(MAX_PLANES);

  logic [CntW-1:0]       idx_q;
  logic [CostW-1:0]      min_q;
  logic [CntW-1:0]       best_q;
  logic                  out_valid_q;
  logic [DepthW-1:0]     out_depth_q;
  logic [CntW-1:0]       out_best_q;
  logic [CostW-1:0]      out_cost_q;

  logic [NumPlanesW-1:0] eff_full;
  logic [CntW:0]         eff;
  logic [CntW:0]         idx_inc;
  logic                  last;
  logic                  upd;
  logic [CntW:0]         best_inc;
  logic [ProdW-1:0]      prod;
  logic [DepthW-1:0]     prod_sat;
  logic [CostW-1:0]      new_min;
  logic [CntW-1:0]       new_best;
  logic                  out_free;
  logic                  take;

  // Plane count in force: zero counts as one, the top is held at the limit.
  always_comb begin
    if (cfg_i.num_planes == '0) begin
      eff_full = NumPlanesW'(1);
    end else if (cfg_i.num_planes > MaxPlanesN) begin
      eff_full = MaxPlanesN;
    end else begin
      eff_full = cfg_i.num_planes;
    end
  end

  assign eff     = eff_full[CntW:0];
  assign idx_inc = {1'b0, idx_q} + (CntW+1)'(1);
  assign last    = idx_inc >= eff;

  // Running minimum; an equal cost keeps the earlier plane.
  assign upd = cost_i < min_q;

  assign new_min  = upd ? cost_i : min_q;
  assign new_best = upd ? idx_q  : best_q;

  // Depth byte of the winner, using the step in force when the pixel closes.
  assign best_inc = {1'b0, new_best} + (CntW+1)'(1);
  assign prod     = ProdW'(cfg_i.depth_step) * ProdW'(best_inc);
  assign prod_sat = (prod > ProdW'(DepthSat)) ? DepthSat : prod[DepthW-1:0];

  // A non-final plane always moves on; the final one needs the result register.
  assign out_free = !out_valid_q || out_ready_i;
  assign ready_o  = !last || out_free;
  assign take     = valid_i && ready_o;

  // Per-pixel running state, cleared after the last plane.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      min_q  <= CostReset;
      best_q <= '0;
    end else if (take) begin
      if (last) begin
        idx_q  <= '0;
        min_q  <= CostReset;
        best_q <= '0;
      end else begin
        idx_q  <= idx_inc[CntW-1:0];
        min_q  <= new_min;
        best_q <= new_best;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && last) begin
      out_depth_q <= prod_sat;
      out_best_q  <= new_best;
      out_cost_q  <= new_min;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign depth_value_o = out_depth_q;
  assign best_plane_o  = PlaneW'(out_best_q);
  assign best_cost_o   = out_cost_q;

endmodule

// ===== design/plane_sweep_depth_select.sv =====
// Channel   Direction  Handshake                       Payload
// config    in/out     psel, penable, pwrite, pready   paddr, pwdata, prdata
// pixel in  in         in_valid_i / in_ready_o         ref_*_i, warp_*_i
// result    out        out_valid_o / out_ready_i       depth_value_o, best_plane_o, best_cost_o
//
// One input word is taken every cycle unless a held result stalls the input; one result
// leaves per pixel, after its last plane. A word passes an input register and then the
// cost compare into the result register, which loads when the last plane's cost is taken.
// Reset clears the per-pixel state and loads 200 planes and a depth step of one.
// A held result stops the last plane of the next pixel in the input register, and the
// input stalls behind it; the planes before it flow on.
module plane_sweep_depth_select #(
  parameter int MAX_PLANES = psds_pkg::MaxPlanesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psds_pkg::CfgAddrW-1:0] paddr,
  input  logic [psds_pkg::CfgDataW-1:0] pwdata,
  output logic [psds_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [psds_pkg::ChanW-1:0]    ref_blue_i,
  input  logic [psds_pkg::ChanW-1:0]    ref_green_i,
  input  logic [psds_pkg::ChanW-1:0]    ref_red_i,
  input  logic [psds_pkg::ChanW-1:0]    warp_blue_i,
  input  logic [psds_pkg::ChanW-1:0]    warp_green_i,
  input  logic [psds_pkg::ChanW-1:0]    warp_red_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [psds_pkg::DepthW-1:0]   depth_value_o,
  output logic [psds_pkg::PlaneW-1:0]   best_plane_o,
  output logic [psds_pkg::CostW-1:0]    best_cost_o
);
  import psds_pkg::*;

  cfg_t             cfg;
  logic             st_valid;
  logic             st_take;
  logic [CostW-1:0] st_cost;

  // Configuration registers.
  psds_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register and matching cost.
  psds_cost u_cost (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ref_blue_i   (ref_blue_i),
    .ref_green_i  (ref_green_i),
    .ref_red_i    (ref_red_i),
    .warp_blue_i  (warp_blue_i),
    .warp_green_i (warp_green_i),
    .warp_red_i   (warp_red_i),
    .valid_o      (st_valid),
    .take_i       (st_take),
    .cost_o       (st_cost)
  );

  // Winner-take-all selection and result register.
  psds_wta #(
    .MAX_PLANES (MAX_PLANES)
  ) u_wta (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .valid_i       (st_valid),
    .ready_o       (st_take),
    .cost_i        (st_cost),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .depth_value_o (depth_value_o),
    .best_plane_o  (best_plane_o),
    .best_cost_o   (best_cost_o)
  );

endmodule

// ===== design/psds_checker.sv =====
module psds_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        pready,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [psds_pkg::DepthW-1:0] depth_value_o,
  input logic [psds_pkg::PlaneW-1:0] best_plane_o,
  input logic [psds_pkg::CostW-1:0]  best_cost_o
);
  import psds_pkg::*;

  // The register port never inserts wait states.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  // A winning cost never exceeds the largest possible cost.
  a_cost_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_cost_o <= CostMax))
    else $error("best_cost out of range");

  // A held result keeps its word until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(depth_value_o) && $stable(best_plane_o) &&
       $stable(best_cost_o)))
    else $error("result changed while stalled");

  // A result appears from empty only after a word was accepted.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input word");

endmodule

bind plane_sweep_depth_select psds_checker u_psds_checker (.*);
